// File: rtl/chs_pkg.sv
package chs_pkg;

  // Fixed field widths of the request and response channels
  localparam int unsigned OpcodeW   = 3;
  localparam int unsigned HandleInW = 32;
  localparam int unsigned PositionW = 4;
  localparam int unsigned DepthNowW = 5;

  // Default configuration
  localparam int unsigned DefStackDepth  = 16;
  localparam int unsigned DefHandleWidth = 32;

  typedef enum logic [OpcodeW-1:0] {
    OpPush   = 3'd0,
    OpPop    = 3'd1,
    OpRdTop  = 3'd2,
    OpRdAt   = 3'd3,
    OpRmAt   = 3'd4,
    OpRmVal  = 3'd5,
    OpMvTop  = 3'd6
  } chs_op_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCmp  = 3'b010,
    StExe  = 3'b100
  } chs_state_e;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic capture;  // latch per-cell match flag
    logic rm_at;    // cells at or above rm_idx take the upper neighbor
    logic rm_val;   // cells at or above the lowest match take the upper neighbor
    logic wr_top;   // cell at top_idx loads the key
    logic clr_top;  // cell at top_idx clears
  } chs_cmd_t;

endpackage

// File: rtl/chs_req_if.sv
interface chs_req_if;
  logic                           valid;
  logic                           ready;
  logic [chs_pkg::OpcodeW-1:0]    opcode;
  logic [chs_pkg::HandleInW-1:0]  handle_in;
  logic [chs_pkg::PositionW-1:0]  position;

  modport source (output valid, output opcode, output handle_in, output position,
                  input ready);
  modport sink   (input valid, input opcode, input handle_in, input position,
                  output ready);
endinterface

// File: rtl/chs_rsp_if.sv
interface chs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [chs_pkg::HandleInW-1:0]  handle_out;
  logic [chs_pkg::DepthNowW-1:0]  depth_now;

  modport source (output valid, output ok, output handle_out, output depth_now,
                  input ready);
  modport sink   (input valid, input ok, input handle_out, input depth_now,
                  output ready);
endinterface

// File: rtl/chs_cell.sv
module chs_cell #(
  parameter int unsigned Idx     = 0,
  parameter int unsigned CntW    = 5,
  parameter int unsigned HandleW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chs_pkg::chs_cmd_t   cmd_i,
  input  logic [HandleW-1:0]  key_i,
  input  logic [CntW-1:0]     count_i,
  input  logic [CntW-1:0]     top_idx_i,
  input  logic [CntW-1:0]     rm_idx_i,
  input  logic [CntW-1:0]     rd_idx_i,
  input  logic [HandleW-1:0]  entry_up_i,
  output logic [HandleW-1:0]  entry_o,
  input  logic                found_i,
  output logic                found_o,
  input  logic [HandleW-1:0]  rd_i,
  output logic [HandleW-1:0]  rd_o
);
  import chs_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic [HandleW-1:0] entry_q;
  logic               match_q;
  logic               is_top;
  logic               shift_en;

  assign is_top   = (MyIdx == top_idx_i);
  assign found_o  = found_i | match_q;
  // found_o is set from the lowest matching cell upward
  assign shift_en = (cmd_i.rm_at && (MyIdx >= rm_idx_i)) || (cmd_i.rm_val && found_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      match_q <= 1'b0;
    end else begin
      if (cmd_i.wr_top && is_top) begin
        entry_q <= key_i;
      end else if (cmd_i.clr_top && is_top) begin
        entry_q <= '0;
      end else if (shift_en) begin
        entry_q <= entry_up_i;
      end
      if (cmd_i.capture) begin
        match_q <= (entry_q == key_i) && (MyIdx < count_i);
      end
    end
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_i | ((MyIdx == rd_idx_i) ? entry_q : '0);

endmodule

// File: rtl/compacting_handle_stack_unit.sv
// Channel  Dir  Payload                               Transaction
// req_i    in   opcode, handle_in, position           valid & ready
// rsp_o    out  ok, handle_out, depth_now             valid & ready
//
// Each request passes through accept, a compare/read pass over the cell
// chain (match flags and read data registered), then the commit cycle that
// shifts/writes the cells and loads the response register.
// A new request is accepted while the previous response still waits; the
// commit cycle holds until the response register is free.
// Reset clears all entries, the count and the control state.
module compacting_handle_stack_unit #(
  parameter int unsigned STACK_DEPTH  = chs_pkg::DefStackDepth,
  parameter int unsigned HANDLE_WIDTH = chs_pkg::DefHandleWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  chs_req_if.sink       req_i,
  chs_rsp_if.source     rsp_o
);
  import chs_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PosCmpW = (CntW > PositionW) ? CntW : PositionW;

  chs_state_e state_q, state_d;

  logic [OpcodeW-1:0]   op_q;
  logic [HANDLE_WIDTH-1:0] key_q;
  logic [PositionW-1:0] pos_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [HANDLE_WIDTH-1:0] rd_q;

  logic                 out_valid_q;
  logic                 ok_q, ok_d;
  logic [HandleInW-1:0] hout_q, hout_d;
  logic [DepthNowW-1:0] depth_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 commit;

  logic                 full, empty, pos_ok, found;
  logic [CntW-1:0]      count_m1;
  logic [CntW-1:0]      top_idx, rd_idx, rm_idx;
  chs_cmd_t             cmd, exe_cmd;
  logic                 rd_sel;

  logic [HANDLE_WIDTH-1:0] entry_c [STACK_DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_c    [STACK_DEPTH+1];
  logic                    found_c [STACK_DEPTH+1];

  assign req_i.ready = (state_q == StIdle);
  assign in_fire     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign commit      = (state_q == StExe) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = StCmp;
      StCmp:   state_d = StExe;
      StExe:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign full     = (count_q == CntW'(STACK_DEPTH));
  assign empty    = (count_q == '0);
  assign pos_ok   = (PosCmpW'(pos_q) < PosCmpW'(count_q));
  assign count_m1 = count_q - CntW'(1);
  assign rm_idx   = CntW'(pos_q);
  assign rd_idx   = (op_q == OpRdAt) ? CntW'(pos_q) : count_m1;
  assign found    = found_c[STACK_DEPTH];

  // Decode of the commit cycle
  always_comb begin
    exe_cmd = '0;
    top_idx = count_q;
    count_d = count_q;
    ok_d    = 1'b0;
    rd_sel  = 1'b0;
    unique case (op_q)
      OpPush: begin
        ok_d = !full;
        if (!full) begin
          exe_cmd.wr_top = 1'b1;
          count_d        = count_q + CntW'(1);
        end
      end
      OpPop: begin
        ok_d    = !empty;
        rd_sel  = 1'b1;
        top_idx = count_m1;
        if (!empty) begin
          exe_cmd.clr_top = 1'b1;
          count_d         = count_m1;
        end
      end
      OpRdTop: begin
        ok_d   = !empty;
        rd_sel = 1'b1;
      end
      OpRdAt: begin
        ok_d   = pos_ok;
        rd_sel = 1'b1;
      end
      OpRmAt: begin
        ok_d = pos_ok;
        if (pos_ok) begin
          exe_cmd.rm_at = 1'b1;
          count_d       = count_m1;
        end
      end
      OpRmVal: begin
        ok_d = found;
        if (found) begin
          exe_cmd.rm_val = 1'b1;
          count_d        = count_m1;
        end
      end
      OpMvTop: begin
        if (found) begin
          // close the gap and rewrite the handle in the freed top slot
          ok_d           = 1'b1;
          exe_cmd.rm_val = 1'b1;
          exe_cmd.wr_top = 1'b1;
          top_idx        = count_m1;
        end else if (!full) begin
          ok_d           = 1'b1;
          exe_cmd.wr_top = 1'b1;
          count_d        = count_q + CntW'(1);
        end
      end
      default: ok_d = 1'b0;
    endcase
    hout_d = (rd_sel && ok_d) ? HandleInW'(rd_q) : '0;
  end

  always_comb begin
    cmd         = commit ? exe_cmd : '0;
    cmd.capture = (state_q == StCmp);
  end

  assign found_c[0] = 1'b0;
  assign rd_c[0]    = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [HANDLE_WIDTH-1:0] entry_up;
    if (i == STACK_DEPTH - 1) begin : g_last
      assign entry_up = '0;
    end else begin : g_mid
      assign entry_up = entry_c[i+1];
    end

    chs_cell #(
      .Idx     (i),
      .CntW    (CntW),
      .HandleW (HANDLE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .key_i      (key_q),
      .count_i    (count_q),
      .top_idx_i  (top_idx),
      .rm_idx_i   (rm_idx),
      .rd_idx_i   (rd_idx),
      .entry_up_i (entry_up),
      .entry_o    (entry_c[i]),
      .found_i    (found_c[i]),
      .found_o    (found_c[i+1]),
      .rd_i       (rd_c[i]),
      .rd_o       (rd_c[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= req_i.opcode;
      key_q <= HANDLE_WIDTH'(req_i.handle_in);
      pos_q <= req_i.position;
    end
    if (state_q == StCmp) begin
      rd_q <= rd_c[STACK_DEPTH];
    end
    if (commit) begin
      ok_q    <= ok_d;
      hout_q  <= hout_d;
      depth_q <= DepthNowW'(count_d);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ok         = ok_q;
  assign rsp_o.handle_out = hout_q;
  assign rsp_o.depth_now  = depth_q;

endmodule

// File: verif/chs_stack_checker.sv
module chs_stack_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  chs_req_if          req_mon,
  chs_rsp_if          rsp_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o
);
  import chs_pkg::*;

  localparam int unsigned Depth = DefStackDepth;

  typedef struct packed {
    logic                 ok;
    logic [HandleInW-1:0] handle;
    logic [DepthNowW-1:0] depth;
  } stack_rsp_t;

  logic [HandleInW-1:0] stack_mem [Depth];
  int unsigned          fill;
  stack_rsp_t           rsp_expect_q [$];
  int unsigned          mismatch_cnt;

  assign mismatch_cnt_o = mismatch_cnt;

  function automatic int find_lowest(logic [HandleInW-1:0] h);
    for (int i = 0; i < int'(fill); i++) begin
      if (stack_mem[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic logic push_handle(logic [HandleInW-1:0] h);
    if (fill >= Depth) return 1'b0;
    stack_mem[fill] = h;
    fill++;
    return 1'b1;
  endfunction

  // close the gap: everything above idx moves down one slot
  task automatic drop_slot(input int unsigned idx);
    for (int unsigned i = idx + 1; i < fill; i++) stack_mem[i-1] = stack_mem[i];
    stack_mem[fill-1] = '0;
    fill--;
  endtask

  task automatic commit_request(input logic [OpcodeW-1:0] op,
                                input logic [HandleInW-1:0] h,
                                input logic [PositionW-1:0] pos,
                                output stack_rsp_t r);
    int hit;
    r = '0;
    case (op)
      OpPush: r.ok = push_handle(h);
      OpPop: begin
        if (fill > 0) begin
          fill--;
          r.handle = stack_mem[fill];
          stack_mem[fill] = '0;
          r.ok = 1'b1;
        end
      end
      OpRdTop: begin
        if (fill > 0) begin
          r.handle = stack_mem[fill-1];
          r.ok = 1'b1;
        end
      end
      OpRdAt: begin
        if (pos < fill) begin
          r.handle = stack_mem[pos];
          r.ok = 1'b1;
        end
      end
      OpRmAt: begin
        if (pos < fill) begin
          drop_slot(pos);
          r.ok = 1'b1;
        end
      end
      OpRmVal: begin
        hit = find_lowest(h);
        if (hit >= 0) begin
          drop_slot(hit);
          r.ok = 1'b1;
        end
      end
      OpMvTop: begin
        hit = find_lowest(h);
        if (hit >= 0) drop_slot(hit);
        r.ok = push_handle(h);
      end
      default: ;  // unknown opcode: no effect
    endcase
    r.depth = fill[DepthNowW-1:0];
  endtask

  task automatic note_mismatch(input string field, input logic [HandleInW-1:0] exp_v,
                               input logic [HandleInW-1:0] act_v);
    $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_rsp_t predicted;
    stack_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(Depth); i++) stack_mem[i] = '0;
      fill = 0;
      rsp_expect_q.delete();
      mismatch_cnt = 0;
      pending_cnt_o <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        commit_request(req_mon.opcode, req_mon.handle_in, req_mon.position, predicted);
        rsp_expect_q.push_back(predicted);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (rsp_expect_q.size() == 0) begin
          $error("response transaction with no request pending");
          mismatch_cnt++;
        end else begin
          want = rsp_expect_q.pop_front();
          if (rsp_mon.ok !== want.ok)
            note_mismatch("ok", HandleInW'(want.ok), HandleInW'(rsp_mon.ok));
          if (rsp_mon.handle_out !== want.handle)
            note_mismatch("handle_out", want.handle, rsp_mon.handle_out);
          if (rsp_mon.depth_now !== want.depth)
            note_mismatch("depth_now", HandleInW'(want.depth), HandleInW'(rsp_mon.depth_now));
        end
      end
      pending_cnt_o <= rsp_expect_q.size();
    end
  end

endmodule

// File: verif/compacting_handle_stack_unit_test.sv
module compacting_handle_stack_unit_test;
  import chs_pkg::*;

  localparam logic [OpcodeW-1:0] OpUnknown  = 3'd7;
  localparam int unsigned        NumPhases  = 19;
  localparam int unsigned        PhaseLen   = 100;
  localparam int unsigned        TailCycles = 10;
  localparam int unsigned        CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  chs_req_if req_if ();
  chs_rsp_if rsp_if ();

  compacting_handle_stack_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  chs_stack_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [OpcodeW-1:0] pick_opcode(int unsigned push_w, int unsigned pop_w);
    int unsigned roll;
    roll = $urandom_range(push_w + pop_w + 60 - 1);
    if (roll < push_w) return OpPush;
    roll -= push_w;
    if (roll < pop_w) return OpPop;
    roll -= pop_w;
    if (roll < 12) return OpMvTop;
    if (roll < 22) return OpRdTop;
    if (roll < 34) return OpRdAt;
    if (roll < 44) return OpRmAt;
    if (roll < 58) return OpRmVal;
    return OpUnknown;
  endfunction

  // mostly a small pool so searches and moves find their handle
  function automatic logic [HandleInW-1:0] pick_handle();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return HandleInW'($urandom_range(7));
      6, 7: return $urandom();
      8: return ~HandleInW'($urandom_range(3));
      default: return '0;
    endcase
  endfunction

  task automatic send_request(input logic [OpcodeW-1:0] op, input logic [HandleInW-1:0] h,
                              input logic [PositionW-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.handle_in <= h;
    req_if.position  <= pos;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // pending count is registered, so look only after the next edge
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("compacting_handle_stack_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned push_w;
    int unsigned pop_w;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.opcode    = OpPush;
    req_if.handle_in = '0;
    req_if.position  = '0;
    idle_pct         = 16;
    stall_pct        = 16;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty stack
    send_request(OpPop, '1, '0);
    send_request(OpRdTop, '0, '0);
    send_request(OpRdAt, '0, '0);
    send_request(OpRmAt, '0, '0);
    send_request(OpUnknown, '1, '1);
    // fill to the limit, zero handle and duplicates included
    for (int i = 0; i < int'(DefStackDepth); i++) begin
      if (i == 1) send_request(OpPush, '1, '1);
      else if (i == 0 || i == 2) send_request(OpPush, '0, '0);
      else send_request(OpPush, HandleInW'(32'h100 + i), '0);
    end
    // full stack
    send_request(OpPush, 32'h55, '0);
    send_request(OpMvTop, 32'h77, '0);
    send_request(OpMvTop, '0, '0);
    send_request(OpRdAt, '0, '1);
    send_request(OpRmVal, '0, '0);
    send_request(OpRmAt, '0, '1);

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase % 3)
        0: begin push_w = 45; pop_w = 5; end
        1: begin push_w = 25; pop_w = 18; end
        default: begin push_w = 8; pop_w = 35; end
      endcase
      if (phase == 7) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 16;
        stall_pct = 16;
      end
      for (int unsigned n = 0; n < PhaseLen; n++)
        send_request(pick_opcode(push_w, pop_w), pick_handle(), PositionW'($urandom_range(15)));
      if (phase == 4) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("compacting_handle_stack_unit regression: pass");
    end else begin
      $display("compacting_handle_stack_unit regression: fail");
    end
    $finish;
  end

endmodule
